### rtl/adcd_pkg.sv
// Package: shared types, codes and constants of the ADC message stream deframer.
package adcd_pkg;

    // Default header size in bytes
    localparam int HEADER_BYTES_DEF = 16;

    // Marker bytes and known message ids
    localparam logic [7:0]  MARKER_P   = 8'h50;
    localparam logic [7:0]  MARKER_S   = 8'h53;
    localparam logic [15:0] ID_DATA    = 16'd20033;
    localparam logic [15:0] ID_ALARM   = 16'd20034;

    // Body offset at which the samples begin, per id
    localparam logic [5:0]  SAMPLES_START_DATA  = 6'h18;
    localparam logic [5:0]  SAMPLES_START_ALARM = 6'h28;

    // Body bytes 12 to 15 are skipped
    localparam logic [31:0] SKIP_FIRST = 32'h0000_000C;
    localparam logic [31:0] SKIP_LAST  = 32'h0000_000F;
    localparam logic [31:0] SECOND_RUN = 32'h0000_0010;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_WORD   = 3'd1,
        KIND_SAMPLE = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MARKER  = 2'd0,
        ERR_SHORT   = 2'd1,
        ERR_UNKNOWN = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_SKIP   = 3'b100
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [15:0]        message_id;
        logic [31:0]        body_length;
        logic [3:0]         word_index;
        logic [31:0]        word_value;
        logic signed [23:0] sample_value;
        err_t               error_code;
        logic               last;
    } result_t;

endpackage

### rtl/adcd_byte_if.sv
// Interface: byte stream channel with valid/ready handshake.
interface adcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/adcd_result_if.sv
// Interface: result channel with valid/ready handshake.
interface adcd_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [15:0]        message_id;
    logic [31:0]        body_length;
    logic [3:0]         word_index;
    logic [31:0]        word_value;
    logic signed [23:0] sample_value;
    logic [1:0]         error_code;
    logic               last;

    modport source (output valid, output kind, output message_id, output body_length,
                    output word_index, output word_value, output sample_value,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input message_id, input body_length,
                    input word_index, input word_value, input sample_value,
                    input error_code, input last, output ready);
endinterface

### rtl/adcd_parser.sv
// Parser: frame state and per-byte decode of header, body words and samples.
module adcd_parser #(
    parameter int HEADER_BYTES = adcd_pkg::HEADER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    output logic              res_valid,
    output adcd_pkg::result_t res
);
    import adcd_pkg::*;

    localparam int HP_W  = $clog2(HEADER_BYTES);
    localparam int HPX_W = HP_W + 1;
    localparam logic [HPX_W-1:0] HP_LAST = HPX_W'(HEADER_BYTES - 1);

    phase_t      phase_reg, phase_next;
    logic [HP_W-1:0] hp_reg, hp_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] id_reg, id_next;
    logic        marker_reg, marker_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  sp_reg, sp_next;

    logic [HPX_W-1:0] hp_ext;
    logic [32:0]      pos_inc;
    logic             len_reached;
    logic [5:0]       start_held;
    logic [5:0]       start_new;
    logic             in_skip_gap;

    // Decode one byte against the current frame state
    always_comb
    begin
        phase_next  = phase_reg;
        hp_next     = hp_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        id_next     = id_reg;
        marker_next = marker_reg;
        shift_next  = shift_reg;
        sp_next     = sp_reg;
        res_valid   = 1'b0;
        res         = '0;

        hp_ext      = HPX_W'(hp_reg);
        pos_inc     = {1'b0, pos_reg} + 33'd1;
        len_reached = pos_inc >= {1'b0, len_reg};
        start_held  = (id_reg == ID_ALARM) ? SAMPLES_START_ALARM : SAMPLES_START_DATA;
        start_new   = SAMPLES_START_DATA;
        in_skip_gap = (pos_reg >= SKIP_FIRST) && (pos_reg <= SKIP_LAST);

        if (accept)
        begin
            case (phase_reg)
                PH_BODY:
                begin
                    shift_next = {shift_reg[23:0], data_byte};
                    if (pos_reg < 32'(start_held))
                    begin
                        // Emit a body word on its fourth byte, outside the gap
                        if (pos_reg[1:0] == 2'b11 && !in_skip_gap)
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_WORD;
                            res.word_index = pos_reg[5:2]
                                             - {3'b000, pos_reg >= SECOND_RUN};
                            res.word_value = shift_next;
                        end
                    end
                    else if (sp_reg >= 2'd2)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_SAMPLE;
                        res.sample_value = shift_next[23:0];
                        sp_next          = 2'd0;
                    end
                    else
                    begin
                        sp_next = sp_reg + 2'd1;
                    end

                    // Close the message on its final body byte
                    if (len_reached)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                        if (!res_valid)
                        begin
                            res.kind = KIND_END;
                        end
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[31:0];
                    end
                end

                PH_SKIP:
                begin
                    // Drop body bytes silently
                    if (len_reached)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_inc[31:0];
                    end
                end

                PH_HEADER:
                begin
                    // Collect markers, id and length
                    if (hp_ext == HPX_W'(0))
                    begin
                        marker_next = (data_byte == MARKER_P);
                    end
                    else if (hp_ext == HPX_W'(1))
                    begin
                        marker_next = marker_reg & (data_byte == MARKER_S);
                    end
                    else if (hp_ext < HPX_W'(4))
                    begin
                        id_next = {id_reg[7:0], data_byte};
                    end
                    else if (hp_ext < HPX_W'(8))
                    begin
                        len_next = {len_reg[23:0], data_byte};
                    end

                    start_new = (id_next == ID_ALARM) ? SAMPLES_START_ALARM
                                                      : SAMPLES_START_DATA;

                    // Judge the header on its last byte
                    if (hp_ext == HP_LAST)
                    begin
                        hp_next   = '0;
                        pos_next  = '0;
                        res_valid = 1'b1;
                        if (!marker_next)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_MARKER;
                            res.last       = 1'b1;
                            phase_next     = PH_HEADER;
                        end
                        else if (id_next != ID_DATA && id_next != ID_ALARM)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_UNKNOWN;
                            res.last       = 1'b1;
                            phase_next     = (len_next != '0) ? PH_SKIP : PH_HEADER;
                        end
                        else if (len_next < 32'(start_new))
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_SHORT;
                            res.last       = 1'b1;
                            phase_next     = (len_next != '0) ? PH_SKIP : PH_HEADER;
                        end
                        else
                        begin
                            res.kind   = KIND_HEADER;
                            phase_next = PH_BODY;
                            sp_next    = '0;
                            shift_next = '0;
                        end
                    end
                    else
                    begin
                        hp_next = hp_reg + HP_W'(1);
                    end
                end

                default:
                begin
                    phase_next = PH_HEADER;
                    hp_next    = '0;
                    pos_next   = '0;
                end
            endcase
        end

        res.message_id  = id_next;
        res.body_length = len_next;
    end

    // Hold the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hp_reg     <= '0;
            pos_reg    <= '0;
            len_reg    <= '0;
            id_reg     <= '0;
            marker_reg <= 1'b1;
            shift_reg  <= '0;
            sp_reg     <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hp_reg     <= hp_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            id_reg     <= id_next;
            marker_reg <= marker_next;
            shift_reg  <= shift_next;
            sp_reg     <= sp_next;
        end
    end

endmodule

### rtl/adc_message_stream_deframer.sv
// Top level: ADC message stream deframer with registered, skid-buffered result channel.
//
// Takes one stream byte per clock while the skid slot is empty and gives at most one
// registered result per byte. The per-byte decode is a single pass of logic from the
// frame state into the result register or the skid slot; that second result slot
// lets bytes keep flowing while the result side stalls, so the sustained rate is one
// byte per clock whenever results are drained, and the stream side only holds off
// while both result slots are full. Messages are parsed back to back: header,
// id-dependent body words, 24-bit samples, or an error result; after an unknown id
// or a short length the rest of the frame is dropped.
module adc_message_stream_deframer #(
    parameter int HEADER_BYTES = adcd_pkg::HEADER_BYTES_DEF
) (
    input logic           clk,
    input logic           rst_n,
    adcd_byte_if.sink     stream,
    adcd_result_if.source result
);
    import adcd_pkg::*;

    logic    accept;
    logic    new_valid;
    result_t new_res;
    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;
    logic    out_fire;

    assign stream.ready = !skid_valid_reg;
    assign accept       = stream.valid && stream.ready;
    assign out_fire     = out_valid_reg && result.ready;

    adcd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (stream.data_byte),
        .res_valid (new_valid),
        .res       (new_res)
    );

    // Advance the output register and the skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (new_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (new_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= new_res;
            end
            else
            begin
                skid_reg <= new_res;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = out_reg.kind;
    assign result.message_id   = out_reg.message_id;
    assign result.body_length  = out_reg.body_length;
    assign result.word_index   = out_reg.word_index;
    assign result.word_value   = out_reg.word_value;
    assign result.sample_value = out_reg.sample_value;
    assign result.error_code   = out_reg.error_code;
    assign result.last         = out_reg.last;

    // A filled skid slot always sits behind a filled output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with empty output register");

    // A header result never closes a message
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == KIND_HEADER) |-> !result.last)
        else $error("header result marked last");

    // Error and end results always close a message
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == KIND_ERROR || result.kind == KIND_END))
            |-> result.last)
        else $error("error or end result not marked last");

    // A new result under a stall goes into the skid slot rather than overwriting the held one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && new_valid) |=> skid_valid_reg)
        else $error("result lost under stall");

endmodule

### verif/tb_adc_message_stream_deframer.sv
// Testbench: ADC message stream deframer, checked result by result against a built-in decoder.
module tb_adc_message_stream_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import adcd_pkg::*;

    localparam int HDR_BYTES = HEADER_BYTES_DEF;

    logic clk = 1'b0;
    logic rst_n;

    adcd_byte_if   byte_ch ();
    adcd_result_if res_ch ();

    adc_message_stream_deframer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch),
        .result (res_ch)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state, mirrors the block's frame state
    phase_t      frame_phase;
    int          hdr_pos;
    logic [31:0] body_pos;
    logic [31:0] msg_len;
    logic [15:0] msg_id;
    logic        marker_ok;
    logic [31:0] word_shift;
    logic [1:0]  sample_cnt;

    result_t     pending_results[$];
    logic [7:0]  frame_bytes[$];

    int fail_count = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int gap_max    = 0;
    int sink_mode  = 0;
    int tick       = 0;

    localparam logic [10:0] STALL_PATTERN = 11'b10011010110;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Queue one byte at the tail of the frame buffer
    task automatic append_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endtask

    // Advance the decoder by one stream byte and queue any result it gives
    task automatic decode_byte(input logic [7:0] b);
        result_t     r;
        logic        emit;
        logic [31:0] pos;
        logic [31:0] nxt;
        logic [5:0]  first_sample;
        r = '0;
        emit = 1'b0;
        case (frame_phase)
            PH_BODY:
            begin
                pos = body_pos;
                nxt = body_pos + 32'd1;
                first_sample = (msg_id == ID_ALARM) ? SAMPLES_START_ALARM : SAMPLES_START_DATA;
                word_shift = {word_shift[23:0], b};
                if (pos < {26'd0, first_sample})
                begin
                    // Words end on every fourth byte, except the dropped run
                    if (pos[1:0] == 2'd3 && (pos < SKIP_FIRST || pos > SKIP_LAST))
                    begin
                        r.kind = KIND_WORD;
                        r.word_index = (pos >= SECOND_RUN) ? pos[5:2] - 4'd1 : pos[5:2];
                        r.word_value = word_shift;
                        emit = 1'b1;
                    end
                end
                else if (sample_cnt >= 2'd2)
                begin
                    r.kind = KIND_SAMPLE;
                    r.sample_value = word_shift[23:0];
                    emit = 1'b1;
                    sample_cnt = 2'd0;
                end
                else
                begin
                    sample_cnt++;
                end
                // Final body byte closes the message
                if (nxt >= msg_len)
                begin
                    frame_phase = PH_HEADER;
                    body_pos = '0;
                    if (!emit)
                    begin
                        r.kind = KIND_END;
                        emit = 1'b1;
                    end
                    r.last = 1'b1;
                end
                else
                begin
                    body_pos = nxt;
                end
            end
            PH_SKIP:
            begin
                nxt = body_pos + 32'd1;
                if (nxt >= msg_len)
                begin
                    frame_phase = PH_HEADER;
                    body_pos = '0;
                end
                else
                begin
                    body_pos = nxt;
                end
            end
            default:
            begin
                if (hdr_pos == 0)
                    marker_ok = (b == MARKER_P);
                else if (hdr_pos == 1)
                    marker_ok = marker_ok & (b == MARKER_S);
                else if (hdr_pos < 4)
                    msg_id = {msg_id[7:0], b};
                else if (hdr_pos < 8)
                    msg_len = {msg_len[23:0], b};

                if (hdr_pos + 1 >= HDR_BYTES)
                begin
                    hdr_pos = 0;
                    body_pos = '0;
                    emit = 1'b1;
                    if (!marker_ok)
                    begin
                        r.kind = KIND_ERROR;
                        r.error_code = ERR_MARKER;
                        r.last = 1'b1;
                        frame_phase = PH_HEADER;
                    end
                    else if (msg_id != ID_DATA && msg_id != ID_ALARM)
                    begin
                        r.kind = KIND_ERROR;
                        r.error_code = ERR_UNKNOWN;
                        r.last = 1'b1;
                        frame_phase = (msg_len != 0) ? PH_SKIP : PH_HEADER;
                    end
                    else if (msg_len < ((msg_id == ID_ALARM) ? {26'd0, SAMPLES_START_ALARM}
                                                             : {26'd0, SAMPLES_START_DATA}))
                    begin
                        r.kind = KIND_ERROR;
                        r.error_code = ERR_SHORT;
                        r.last = 1'b1;
                        frame_phase = (msg_len != 0) ? PH_SKIP : PH_HEADER;
                    end
                    else
                    begin
                        r.kind = KIND_HEADER;
                        frame_phase = PH_BODY;
                        sample_cnt = 2'd0;
                        word_shift = '0;
                    end
                end
                else
                begin
                    hdr_pos++;
                end
            end
        endcase
        if (emit)
        begin
            r.message_id = msg_id;
            r.body_length = msg_len;
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    // Send one item, idling between bursts, and hold until it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        decode_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic put_header(input logic [7:0] m0, input logic [7:0] m1,
                              input logic [15:0] id, input logic [31:0] len);
        append_byte(m0);
        append_byte(m1);
        append_byte(id[15:8]);
        append_byte(id[7:0]);
        append_byte(len[31:24]);
        append_byte(len[23:16]);
        append_byte(len[15:8]);
        append_byte(len[7:0]);
        // Timestamp bytes carry nothing
        for (int i = 8; i < HDR_BYTES; i++)
            append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic put_random(input int count);
        for (int i = 0; i < count; i++)
            append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_frames();
        while (frame_bytes.size() != 0)
            send_byte(frame_bytes.pop_front());
    endtask

    // Extremes, every kind of result and each error path
    task automatic test_directed();
        gap_max = 3;
        sink_mode = 1;
        // Data message, words all zero then all ones, ends on a word
        put_header(MARKER_P, MARKER_S, ID_DATA, 32'd24);
        for (int i = 0; i < 24; i++)
            append_byte((i < 12) ? 8'h00 : 8'hFF);
        // Data message with extreme samples and two trailing bytes
        put_header(MARKER_P, MARKER_S, ID_DATA, 32'd35);
        put_random(24);
        append_byte(8'h80); append_byte(8'h00); append_byte(8'h00);
        append_byte(8'h7F); append_byte(8'hFF); append_byte(8'hFF);
        append_byte(8'hFF); append_byte(8'hFF); append_byte(8'hFF);
        put_random(2);
        // Alarm message ending on a sample, then one ending on a trailing byte
        put_header(MARKER_P, MARKER_S, ID_ALARM, 32'd43);
        put_random(40);
        append_byte(8'h00); append_byte(8'h00); append_byte(8'h01);
        put_header(MARKER_P, MARKER_S, ID_ALARM, 32'd41);
        put_random(41);
        // Bad markers, no body follows
        put_header(8'h58, MARKER_S, 16'hFFFF, 32'hFFFF_FFFF);
        put_header(MARKER_P, 8'h54, 16'h0000, 32'h0000_0000);
        put_header(MARKER_S, MARKER_P, ID_DATA, 32'd24);
        // Unknown ids, empty and with a body to drop
        put_header(MARKER_P, MARKER_S, 16'h0000, 32'd0);
        put_header(MARKER_P, MARKER_S, ID_ALARM + 16'd1, 32'd7);
        put_random(7);
        // Short bodies
        put_header(MARKER_P, MARKER_S, ID_DATA, 32'd23);
        put_random(23);
        put_header(MARKER_P, MARKER_S, ID_ALARM, 32'd24);
        put_random(24);
        put_header(MARKER_P, MARKER_S, ID_DATA, 32'd0);
        // Good message after the errors
        put_header(MARKER_P, MARKER_S, ID_DATA, 32'd30);
        put_random(30);
        send_frames();
    endtask

    // Mostly well-formed messages with random content, some broken headers
    task automatic run_random_messages(input int n_bytes);
        int          sel;
        int          nsamp;
        logic [15:0] id;
        logic [31:0] len;
        logic [7:0]  m0;
        logic [7:0]  m1;
        int          stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                id = (sel < 40) ? ID_DATA : ID_ALARM;
                nsamp = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 60)
                                                     : $urandom_range(0, 6);
                len = ((id == ID_ALARM) ? 32'd40 : 32'd24) + 3 * nsamp + $urandom_range(0, 2);
                put_header(MARKER_P, MARKER_S, id, len);
                put_random(len);
            end
            else if (sel < 78)
            begin
                id = $urandom_range(0, 1) ? ID_DATA : ID_ALARM;
                len = $urandom_range(0, (id == ID_ALARM) ? 39 : 23);
                put_header(MARKER_P, MARKER_S, id, len);
                put_random(len);
            end
            else if (sel < 88)
            begin
                do
                    id = 16'($urandom_range(0, 65535));
                while (id == ID_DATA || id == ID_ALARM);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300)
                                                  : $urandom_range(0, 12);
                put_header(MARKER_P, MARKER_S, id, len);
                put_random(len);
            end
            else
            begin
                // Broken marker with any id and length
                m0 = 8'($urandom_range(0, 255));
                m1 = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 2))
                    0: m0 = MARKER_P;
                    1: m1 = MARKER_S;
                    default: ;
                endcase
                if (m0 == MARKER_P && m1 == MARKER_S)
                    m1 = ~m1;
                put_header(m0, m1, 16'($urandom_range(0, 65535)), 32'($urandom));
            end
            send_frames();
        end
    endtask

    task automatic test_random_flow();
        gap_max = 6;
        sink_mode = 1;
        run_random_messages(450);
    endtask

    task automatic test_back_pressure();
        gap_max = 0;
        sink_mode = 2;
        run_random_messages(450);
    endtask

    task automatic test_full_rate();
        gap_max = 0;
        sink_mode = 0;
        run_random_messages(450);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Check each accepted result, then set the next ready
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report($sformatf("result of kind %0d with nothing pending", res_ch.kind));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", {29'd0, res_ch.kind}, {29'd0, want.kind});
                check_field("message_id", {16'd0, res_ch.message_id}, {16'd0, want.message_id});
                check_field("body_length", res_ch.body_length, want.body_length);
                check_field("word_index", {28'd0, res_ch.word_index}, {28'd0, want.word_index});
                check_field("word_value", res_ch.word_value, want.word_value);
                check_field("sample_value", {8'd0, res_ch.sample_value},
                            {8'd0, want.sample_value});
                check_field("error_code", {30'd0, res_ch.error_code}, {30'd0, want.error_code});
                check_field("last", {31'd0, res_ch.last}, {31'd0, want.last});
            end
        end
        tick++;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            case (sink_mode)
                1: res_ch.ready <= tick[6] ? 1'b1 : ($urandom_range(0, 2) != 0);
                2: res_ch.ready <= STALL_PATTERN[tick % 11];
                default: res_ch.ready <= 1'b1;
            endcase
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        res_ch.ready = 1'b0;
        frame_phase = PH_HEADER;
        hdr_pos = 0;
        body_pos = '0;
        msg_len = '0;
        msg_id = '0;
        marker_ok = 1'b1;
        word_shift = '0;
        sample_cnt = 2'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_flow();
        test_back_pressure();
        test_full_rate();

        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[adc_message_stream_deframer] OK");
        else
            $display("[adc_message_stream_deframer] ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("[adc_message_stream_deframer] ERROR");
        $finish;
    end

endmodule
